// ----- hw/rtl/single_wire_link_target_macros.svh -----
// assertion macros for the single-wire link target
`ifndef SINGLE_WIRE_LINK_TARGET_MACROS_SVH
`define SINGLE_WIRE_LINK_TARGET_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/swl_pkg.sv -----
// package with types and constants of the single-wire link target
package swl_pkg;

    localparam int OUT_LEN_DEF = 32;
    localparam int CMD_LEN_DEF = 32;

    localparam logic [7:0] BYTE_FLOW_CMD  = 8'h0B;
    localparam logic [7:0] BYTE_ID_REQ    = 8'h0C;
    localparam logic [7:0] BYTE_CMD_START = 8'h1A;
    localparam logic [7:0] BYTE_END       = 8'h17;
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] ID_NONE        = 8'h15;
    localparam logic [7:0] ID_PROC        = 8'h11;
    localparam logic [7:0] ID_LOG         = 8'h12;
    localparam logic [7:0] ID_CMD         = 8'h13;

    localparam int FLAG_CMD = 3;

    typedef enum logic [2:0] {
        KIND_RX          = 3'd0,
        KIND_TX_DONE     = 3'd1,
        KIND_WRITE_OUT   = 3'd2,
        KIND_MARK_VALID  = 3'd3,
        KIND_READ_CMD    = 3'd4,
        KIND_RELEASE_CMD = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_FLOW      = 3'd0,
        PH_CID_IN    = 3'd1,
        PH_CMD_RX    = 3'd2,
        PH_ID_WAIT   = 3'd3,
        PH_DATA_WAIT = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CH_NONE = 2'd0,
        CH_PROC = 2'd1,
        CH_LOG  = 2'd2,
        CH_CMD  = 2'd3
    } choice_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_BURST = 2'd2,
        ST_TAIL  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [1:0] buffer_select;
        logic [4:0] byte_index;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] read_byte;
        logic       cmd_ready;
        logic [2:0] out_pending;
    } result_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic burst_emit;
        logic tail_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic burst_start;
        logic burst_end;
    } dp_status_t;

endpackage

// ----- hw/rtl/single_wire_link_target.sv -----
// top level of the single-wire link target
//
// input channel in_valid/in_stall carries one item beat: an rx byte, a
// transmit-done, an out-buffer write or mark, a command-store read or a
// command release. output channel out_valid/out_stall carries result beats;
// last marks the final beat caused by one item. debug_mode is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. an item is captured into the item
// register and executed in the exec state, which waits for a free output
// register; its result is then registered in the output register. a
// transmit-done that opens a string gives up to OUT_LEN-2 string beats, then
// 0x00 and 0x17, one beat per cycle while the receiver does not stall, paced
// by the single read port of the out store.
// reset puts the link in the flow-byte wait, clears the valid mask, the
// command count and debug_mode; the out and command stores are not cleared.
// a stalled receiver holds the output register; the block then holds its
// work; the input is stalled whenever the controller is out of the idle state.
module single_wire_link_target #(
    parameter int OUT_LEN = swl_pkg::OUT_LEN_DEF,
    parameter int CMD_LEN = swl_pkg::CMD_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  swl_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output swl_pkg::result_t out_item,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data
);
    import swl_pkg::*;

`include "single_wire_link_target_macros.svh"

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    swl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    swl_datapath #(
        .OUT_LEN (OUT_LEN),
        .CMD_LEN (CMD_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_item    (out_item),
        .cmd         (cmd),
        .sts         (sts)
    );

    `SWL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat not held busy")
    `SWL_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "controller commands overlap")
    `SWL_ASSERT_IMP(a_emit_free, cmd.burst_emit || cmd.tail_emit, sts.out_free, "emit into full output")
    `SWL_ASSERT_NEXT(a_tail_beat, cmd.tail_emit, out_valid && out_item.last && out_item.tx_byte == BYTE_END, "tail beat wrong")

endmodule

// ----- hw/rtl/swl_ctrl.sv -----
// controller state machine of the single-wire link target
module swl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swl_pkg::dp_status_t sts,
    output swl_pkg::ctrl_cmd_t  cmd
);
    import swl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.burst_start ? ST_BURST : ST_IDLE;
                end
            end
            ST_BURST:
            begin
                if (sts.out_free && sts.burst_end)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.exec       = (state_reg == ST_EXEC) && sts.out_free;
        cmd.burst_emit = (state_reg == ST_BURST) && sts.out_free;
        cmd.tail_emit  = (state_reg == ST_TAIL) && sts.out_free;
    end

endmodule

// ----- hw/rtl/swl_datapath.sv -----
// datapath of the single-wire link target: link state, stores and result register
module swl_datapath #(
    parameter int OUT_LEN = swl_pkg::OUT_LEN_DEF,
    parameter int CMD_LEN = swl_pkg::CMD_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swl_pkg::item_t      in_item,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                out_stall,
    output logic                out_valid,
    output swl_pkg::result_t    out_item,
    input  swl_pkg::ctrl_cmd_t  cmd,
    output swl_pkg::dp_status_t sts
);
    import swl_pkg::*;

    localparam int OUT_DEPTH = 3 * OUT_LEN;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int BW        = (OUT_LEN > 2) ? $clog2(OUT_LEN) : 1;
    localparam int CAW       = $clog2(CMD_LEN);

    logic [7:0] out_mem [OUT_DEPTH];
    logic [7:0] cmd_mem [CMD_LEN];

    item_t       item_reg;
    logic        debug_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  flags_reg, flags_next;
    logic [CAW-1:0] cnt_reg, cnt_next;
    choice_t     choice_reg, choice_next;
    logic [BW-1:0] bidx_reg, bidx_next;
    logic [7:0]  out_rd_reg;
    logic [7:0]  cmd_rd_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    logic              out_we, out_re, cmd_we, cmd_re;
    logic [OUT_AW-1:0] out_waddr, out_raddr, burst_base;
    logic [CAW-1:0]    cmd_waddr;
    logic [7:0]        cmd_wdata;
    logic              load;
    logic              tx_v;
    logic [7:0]        tx_b;
    logic [7:0]        rd_b;
    choice_t           pick_choice;
    logic [7:0]        pick_id;

    // registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debug_reg     <= 1'b0;
            phase_reg     <= PH_FLOW;
            flags_reg     <= 4'd0;
            cnt_reg       <= '0;
            choice_reg    <= CH_NONE;
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debug_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            cnt_reg       <= cnt_next;
            choice_reg    <= choice_next;
            bidx_reg      <= bidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    // out store
    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= item_reg.data_byte;
        end
        if (out_re)
        begin
            out_rd_reg <= out_mem[out_raddr];
        end
    end

    // command store
    always_ff @(posedge clk)
    begin
        if (cmd_we)
        begin
            cmd_mem[cmd_waddr] <= cmd_wdata;
        end
        if (cmd_re)
        begin
            cmd_rd_reg <= cmd_mem[CAW'(in_item.byte_index)];
        end
    end

    assign cmd_re = cmd.capture && (32'(in_item.byte_index) < 32'(CMD_LEN));

    assign sts.out_free    = !out_valid_reg || !out_stall;
    assign sts.burst_start = (kind_t'(item_reg.kind) == KIND_TX_DONE)
                             && (phase_reg == PH_ID_WAIT) && (choice_reg != CH_NONE);
    assign sts.burst_end   = (bidx_reg == BW'(OUT_LEN - 2)) || (out_rd_reg == BYTE_NUL);

    assign burst_base = OUT_AW'(2'(choice_reg) - 2'd1) * OUT_AW'(OUT_LEN);
    assign out_waddr  = OUT_AW'(item_reg.buffer_select) * OUT_AW'(OUT_LEN)
                        + OUT_AW'(item_reg.byte_index);

    // priority pick of the content to announce
    always_comb
    begin
        priority if (flags_reg[2])
        begin
            pick_choice = CH_CMD;
            pick_id     = ID_CMD;
        end
        else if (flags_reg[1])
        begin
            pick_choice = CH_LOG;
            pick_id     = ID_LOG;
        end
        else if (flags_reg[0])
        begin
            pick_choice = CH_PROC;
            pick_id     = ID_PROC;
        end
        else
        begin
            pick_choice = CH_NONE;
            pick_id     = ID_NONE;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        cnt_next       = cnt_reg;
        choice_next    = choice_reg;
        bidx_next      = bidx_reg;
        out_we         = 1'b0;
        out_re         = 1'b0;
        out_raddr      = burst_base;
        cmd_we         = 1'b0;
        cmd_waddr      = '0;
        cmd_wdata      = BYTE_NUL;
        load           = 1'b0;
        tx_v           = 1'b0;
        tx_b           = BYTE_NUL;
        rd_b           = BYTE_NUL;
        res_next       = '0;

        if (cmd.exec)
        begin
            unique case (item_reg.kind)
                KIND_RX:
                begin
                    unique case (phase_reg)
                        PH_FLOW:
                        begin
                            if (item_reg.data_byte == BYTE_FLOW_CMD)
                            begin
                                phase_next = PH_CID_IN;
                            end
                            if (debug_reg && item_reg.data_byte == BYTE_ID_REQ)
                            begin
                                choice_next = pick_choice;
                                phase_next  = PH_ID_WAIT;
                                tx_v        = 1'b1;
                                tx_b        = pick_id;
                            end
                        end
                        PH_CID_IN:
                        begin
                            if (item_reg.data_byte == BYTE_CMD_START && !flags_reg[FLAG_CMD])
                            begin
                                cnt_next   = '0;
                                cmd_we     = 1'b1;
                                phase_next = PH_CMD_RX;
                            end
                            else
                            begin
                                phase_next = PH_FLOW;
                            end
                        end
                        PH_CMD_RX:
                        begin
                            priority if (item_reg.data_byte == BYTE_ID_REQ)
                            begin
                                cmd_we      = 1'b1;
                                choice_next = pick_choice;
                                phase_next  = PH_ID_WAIT;
                                tx_v        = 1'b1;
                                tx_b        = pick_id;
                            end
                            else if (item_reg.data_byte == BYTE_END)
                            begin
                                cmd_we               = 1'b1;
                                cmd_waddr            = cnt_reg;
                                flags_next[FLAG_CMD] = 1'b1;
                                phase_next           = PH_FLOW;
                            end
                            else if (32'(cnt_reg) < 32'(CMD_LEN - 1))
                            begin
                                cmd_we    = 1'b1;
                                cmd_waddr = cnt_reg;
                                cmd_wdata = item_reg.data_byte;
                                cnt_next  = CAW'(cnt_reg + 1'b1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                KIND_TX_DONE:
                begin
                    if (phase_reg == PH_ID_WAIT)
                    begin
                        if (choice_reg == CH_NONE)
                        begin
                            phase_next = PH_FLOW;
                        end
                        else
                        begin
                            phase_next = PH_DATA_WAIT;
                            bidx_next  = '0;
                            out_re     = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_DATA_WAIT)
                    begin
                        if (choice_reg != CH_NONE)
                        begin
                            flags_next[2'(choice_reg) - 2'd1] = 1'b0;
                        end
                        choice_next = CH_NONE;
                        phase_next  = PH_FLOW;
                    end
                end
                KIND_WRITE_OUT:
                begin
                    out_we = (item_reg.buffer_select != 2'd3)
                             && (32'(item_reg.byte_index) < 32'(OUT_LEN));
                end
                KIND_MARK_VALID:
                begin
                    if (item_reg.buffer_select != 2'd3)
                    begin
                        flags_next[item_reg.buffer_select] = 1'b1;
                    end
                end
                KIND_READ_CMD:
                begin
                    if (32'(item_reg.byte_index) < 32'(CMD_LEN))
                    begin
                        rd_b = cmd_rd_reg;
                    end
                end
                KIND_RELEASE_CMD:
                begin
                    flags_next[FLAG_CMD] = 1'b0;
                end
                default:
                begin
                end
            endcase

            load                 = !sts.burst_start;
            res_next.tx_valid    = tx_v;
            res_next.tx_byte     = tx_b;
            res_next.last        = 1'b1;
            res_next.read_byte   = rd_b;
            res_next.cmd_ready   = flags_next[FLAG_CMD];
            res_next.out_pending = flags_next[2:0];
        end
        else if (cmd.burst_emit)
        begin
            load                 = 1'b1;
            res_next.tx_valid    = 1'b1;
            res_next.cmd_ready   = flags_reg[FLAG_CMD];
            res_next.out_pending = flags_reg[2:0];
            if (sts.burst_end)
            begin
                res_next.tx_byte = BYTE_NUL;
            end
            else
            begin
                res_next.tx_byte = out_rd_reg;
                bidx_next        = BW'(bidx_reg + 1'b1);
                out_re           = 1'b1;
                out_raddr        = burst_base + OUT_AW'(bidx_next);
            end
        end
        else if (cmd.tail_emit)
        begin
            load                 = 1'b1;
            res_next.tx_valid    = 1'b1;
            res_next.tx_byte     = BYTE_END;
            res_next.last        = 1'b1;
            res_next.cmd_ready   = flags_reg[FLAG_CMD];
            res_next.out_pending = flags_reg[2:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = res_reg;

endmodule
